// File: design/fbsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsd_pkg: shared types and constants
// Configuration layout, queue item and result beat types, sync patterns.
// ----------------------------------------------------------------------------
package fbsd_pkg;

  localparam logic [1:0] CFG_CELL_TICKS  = 2'd0;
  localparam logic [1:0] CFG_SYNC_MODE   = 2'd1;
  localparam logic [1:0] CFG_TOTAL_WORDS = 2'd2;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_FM   = 2'd1;
  localparam logic [1:0] MODE_MFM  = 2'd2;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_HUNT    = 2'd1;
  localparam logic [1:0] PH_CAPTURE = 2'd2;
  localparam logic [1:0] PH_DONE    = 2'd3;

  localparam logic [11:0] CELL_TICKS_RESET  = 12'd144;
  localparam logic [15:0] TOTAL_WORDS_RESET = 16'd1;
  localparam logic [11:0] MIN_CELL          = 12'd64;

  localparam logic [31:0] FM_MASK  = 32'hffffd555;
  localparam logic [31:0] FM_SYNC  = 32'h55555015;
  localparam logic [31:0] MFM_SYNC = 32'h44894489;

  localparam logic [20:0] FM_SYNC_COUNT  = 21'd31;
  localparam logic [20:0] MFM_SYNC_COUNT = 21'd32;

  typedef struct packed {
    logic [11:0] cell_ticks;
    logic [1:0]  sync_mode;
    logic [15:0] total_words;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [15:0] sample;
  } item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [15:0] word_index;
    logic        sync_word;
    logic        long_flux;
    logic        track_done;
    logic        last_in_run;
  } result_t;

endpackage

// File: design/fbsd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsd_front: input acceptance and classification
// Decodes the command and parks items in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module fbsd_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           cmd,
  input  logic [15:0]    sample,
  output logic           q_valid,
  output fbsd_pkg::item_t q_item,
  input  logic           q_pop
);

  fbsd_pkg::item_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;
  logic            push;
  logic            pop;

  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].start  <= ~cmd;
      slots[wr_ptr].sample <= sample;
    end
  end

endmodule

// File: design/fbsd_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsd_engine: bitcell engine
// Cuts flux intervals into bitcells one per cycle unless the output stalls, hunts sync, packs words.
// ----------------------------------------------------------------------------
module fbsd_engine (
  input  logic              clk,
  input  logic              rst,
  input  fbsd_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  fbsd_pkg::item_t   q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output fbsd_pkg::result_t out_res
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]  state;
  logic [1:0]  phase;
  logic [15:0] prev;
  logic [31:0] win;
  logic [20:0] cnt;
  logic        lfp;
  logic [15:0] rem;
  logic        hold_valid;
  fbsd_pkg::result_t hold;

  logic [11:0] cell_len;
  logic [12:0] half_win;
  logic [14:0] six_cell;
  logic [15:0] limit;
  logic [20:0] limit32;
  logic [15:0] delta;
  logic        bit_zero;
  logic [31:0] new_win;
  logic [20:0] new_cnt;
  logic        emit_word;
  logic        done_hit;
  logic        sync_match;
  logic        sync_hit;
  logic        emit;
  logic        out_free;
  logic        step_ok;
  logic        item_end;
  logic        out_load;
  fbsd_pkg::result_t res_new;
  fbsd_pkg::result_t out_data;

  always_comb begin
    cell_len = (cfg.cell_ticks < fbsd_pkg::MIN_CELL) ? fbsd_pkg::MIN_CELL : cfg.cell_ticks;
    half_win = {1'b0, cell_len} + {2'b00, cell_len[11:1]};
    six_cell = {1'b0, cell_len, 2'b00} + {2'b00, cell_len, 1'b0};
    limit    = (cfg.total_words == 16'd0) ? 16'd1 : cfg.total_words;
    limit32  = {limit, 5'd0};
    delta    = q_item.sample - prev;

    bit_zero  = rem > {3'b000, half_win};
    new_win   = {win[30:0], ~bit_zero};
    new_cnt   = cnt + 21'd1;
    emit_word = (phase == fbsd_pkg::PH_CAPTURE) && (new_cnt[4:0] == 5'd0);
    done_hit  = emit_word && (new_cnt >= limit32);

    sync_match = 1'b0;
    case (cfg.sync_mode)
      fbsd_pkg::MODE_FM:  sync_match = (new_win & fbsd_pkg::FM_MASK) == fbsd_pkg::FM_SYNC;
      fbsd_pkg::MODE_MFM: sync_match = (new_win == fbsd_pkg::MFM_SYNC);
      default:            sync_match = 1'b0;
    endcase
    sync_hit = (phase == fbsd_pkg::PH_HUNT) && !bit_zero && sync_match;
    emit     = emit_word || sync_hit;

    out_free = !out_valid || !out_stall;
    step_ok  = !(emit && hold_valid && !out_free);
    item_end = !bit_zero || done_hit;

    res_new.word        = new_win;
    res_new.word_index  = emit_word ? (new_cnt[20:5] - 16'd1) : 16'd0;
    res_new.sync_word   = sync_hit;
    res_new.long_flux   = lfp;
    res_new.track_done  = done_hit;
    res_new.last_in_run = 1'b0;

    out_load = 1'b0;
    out_data = hold;
    if (state == ST_RUN && step_ok && emit && hold_valid) begin
      out_load             = 1'b1;
      out_data.last_in_run = 1'b0;
    end else if (state == ST_FLUSH && out_free) begin
      out_load             = 1'b1;
      out_data.last_in_run = 1'b1;
    end

    q_pop = (state == ST_IDLE) && q_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= fbsd_pkg::PH_IDLE;
      prev       <= 16'd0;
      win        <= '1;
      cnt        <= 21'd0;
      lfp        <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_item.start) begin
              prev  <= q_item.sample;
              win   <= '1;
              cnt   <= 21'd0;
              lfp   <= 1'b0;
              phase <= (cfg.sync_mode == fbsd_pkg::MODE_FM ||
                        cfg.sync_mode == fbsd_pkg::MODE_MFM) ?
                       fbsd_pkg::PH_HUNT : fbsd_pkg::PH_CAPTURE;
            end else if (phase == fbsd_pkg::PH_HUNT || phase == fbsd_pkg::PH_CAPTURE) begin
              prev  <= q_item.sample;
              rem   <= delta;
              if (delta > {1'b0, six_cell}) begin
                lfp <= 1'b1;
              end
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (step_ok) begin
            win <= new_win;
            if (bit_zero) begin
              rem <= rem - {4'd0, cell_len};
            end
            if (sync_hit) begin
              cnt   <= (cfg.sync_mode == fbsd_pkg::MODE_FM) ?
                       fbsd_pkg::FM_SYNC_COUNT : fbsd_pkg::MFM_SYNC_COUNT;
              phase <= fbsd_pkg::PH_CAPTURE;
            end else begin
              cnt <= new_cnt;
            end
            if (done_hit) begin
              phase <= fbsd_pkg::PH_DONE;
            end
            if (emit) begin
              lfp        <= 1'b0;
              hold_valid <= 1'b1;
            end
            if (item_end) begin
              state <= (emit || hold_valid) ? ST_FLUSH : ST_IDLE;
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            hold_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == ST_RUN && step_ok && emit) begin
      hold <= res_new;
    end
    if (out_load) begin
      out_res <= out_data;
    end
  end

endmodule

// File: design/flux_to_bitcell_sync_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flux_to_bitcell_sync_decoder: flux-to-bitcell data separator
// Timer captures in, 32-bit bitcell words out, with FM / MFM sync search.
// ----------------------------------------------------------------------------
// A start beat is consumed in the idle state. A flux beat is taken in the idle
// state and cut into bitcells in the run state, one per cycle unless the output
// stalls; a beat that yields words ends in the flush state before going idle.
// Words wait in a one-deep hold until the next word or the end of the beat.
// A two-entry input queue lets the front accept while the engine works.
// Synchronous reset clears the queue, engine state and output valid.
module flux_to_bitcell_sync_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [15:0] sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] word,
  output logic [15:0] word_index,
  output logic        sync_word,
  output logic        long_flux,
  output logic        track_done,
  output logic        last_in_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  fbsd_pkg::cfg_t    cfg;
  fbsd_pkg::item_t   q_item;
  fbsd_pkg::result_t out_res;
  logic              q_valid;
  logic              q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cell_ticks  <= fbsd_pkg::CELL_TICKS_RESET;
      cfg.sync_mode   <= fbsd_pkg::MODE_NONE;
      cfg.total_words <= fbsd_pkg::TOTAL_WORDS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fbsd_pkg::CFG_CELL_TICKS:  cfg.cell_ticks  <= cfg_data[11:0];
        fbsd_pkg::CFG_SYNC_MODE:   cfg.sync_mode   <= cfg_data[1:0];
        fbsd_pkg::CFG_TOTAL_WORDS: cfg.total_words <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fbsd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sample   (sample),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  fbsd_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign word        = out_res.word;
  assign word_index  = out_res.word_index;
  assign sync_word   = out_res.sync_word;
  assign long_flux   = out_res.long_flux;
  assign track_done  = out_res.track_done;
  assign last_in_run = out_res.last_in_run;

endmodule

// File: design/fbsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsd_checker: port-level checks
// Watches the decoder's ports; attached to the top level by bind.
// ----------------------------------------------------------------------------
module fbsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] word,
  input logic [15:0] word_index,
  input logic        sync_word,
  input logic        track_done,
  input logic        last_in_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(word) && $stable(word_index))
    else $error("stalled result beat changed");

  a_sync_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && sync_word |-> word_index == 16'd0 && !track_done)
    else $error("sync beat with nonzero index or done");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && track_done |-> last_in_run)
    else $error("final word not last of its run");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat straight after reset");

endmodule

bind flux_to_bitcell_sync_decoder fbsd_checker u_fbsd_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .word        (word),
  .word_index  (word_index),
  .sync_word   (sync_word),
  .track_done  (track_done),
  .last_in_run (last_in_run)
);

// File: tb/fbsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsd_tb_checker: result predictor and scoreboard for the data separator
// Watches the config, flux and word channels, predicts each word with a
// private copy of the separator state and compares it with the word beats.
// ----------------------------------------------------------------------------
module fbsd_tb_checker
  import fbsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        cmd,
  input  logic [15:0] sample,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] word,
  input  logic [15:0] word_index,
  input  logic        sync_word,
  input  logic        long_flux,
  input  logic        track_done,
  input  logic        last_in_run,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          work_beats
);

  logic [11:0] cell_ticks;
  logic [1:0]  mode;
  logic [15:0] tot_words;

  logic [15:0] prev;
  logic [31:0] win;
  logic [20:0] nbits;
  logic [1:0]  ph;
  logic        lf_pend;

  result_t     word_q[$];
  result_t     held;
  logic        have_held;
  int          nerr;
  int          n_work;

  // last_in_run is only known once the beat is done, so hold one word back
  task automatic emit(input logic [31:0] w, input logic [15:0] idx,
                      input logic is_sync, input logic done);
    if (have_held) word_q.push_back(held);
    held.word        = w;
    held.word_index  = idx;
    held.sync_word   = is_sync;
    held.long_flux   = lf_pend;
    held.track_done  = done;
    held.last_in_run = 1'b0;
    have_held        = 1'b1;
    lf_pend          = 1'b0;
  endtask

  task automatic shift_cell(input logic b, output logic fin);
    logic [21:0] lim;
    lim  = (tot_words == 16'd0) ? 22'd32 : {1'b0, tot_words, 5'd0};
    fin  = 1'b0;
    win  = {win[30:0], b};
    nbits = nbits + 21'd1;
    if (ph == PH_CAPTURE && nbits[4:0] == 5'd0) begin
      fin = ({1'b0, nbits} >= lim);
      emit(win, nbits[20:5] - 16'd1, 1'b0, fin);
      if (fin) ph = PH_DONE;
    end
  endtask

  task automatic predict_beat(input logic c, input logic [15:0] s);
    logic [15:0] cell_w;
    logic [15:0] span;
    logic [15:0] delta;
    logic        fin;
    logic        hit;
    have_held = 1'b0;
    if (c == 1'b0) begin
      n_work++;
      prev    = s;
      win     = '1;
      nbits   = '0;
      lf_pend = 1'b0;
      ph      = (mode == MODE_FM || mode == MODE_MFM) ? PH_HUNT : PH_CAPTURE;
    end else if (ph == PH_HUNT || ph == PH_CAPTURE) begin
      n_work++;
      cell_w = (cell_ticks < MIN_CELL) ? 16'(MIN_CELL) : 16'(cell_ticks);
      span   = cell_w + (cell_w >> 1);
      delta  = s - prev;
      prev   = s;
      if (delta > cell_w * 16'd6) lf_pend = 1'b1;
      if (ph == PH_HUNT) begin
        while (delta > span) begin
          delta = delta - cell_w;
          shift_cell(1'b0, fin);
        end
        shift_cell(1'b1, fin);
        hit = 1'b0;
        if (mode == MODE_FM && (win & FM_MASK) == FM_SYNC) begin
          nbits = FM_SYNC_COUNT;
          hit   = 1'b1;
        end else if (mode == MODE_MFM && win == MFM_SYNC) begin
          nbits = MFM_SYNC_COUNT;
          hit   = 1'b1;
        end
        if (hit) begin
          ph = PH_CAPTURE;
          emit(win, 16'd0, 1'b1, 1'b0);
        end
      end else begin
        fin = 1'b0;
        while (delta > span && !fin) begin
          delta = delta - cell_w;
          shift_cell(1'b0, fin);
        end
        if (!fin) shift_cell(1'b1, fin);
      end
    end
    if (have_held) begin
      held.last_in_run = 1'b1;
      word_q.push_back(held);
    end
  endtask

  task automatic check_word();
    result_t want;
    if (word_q.size() == 0) begin
      if (nerr < 10)
        $display("unexpected word %h index %0d at %0t", word, word_index, $realtime);
      nerr++;
    end else begin
      want = word_q.pop_front();
      if (word !== want.word || word_index !== want.word_index ||
          sync_word !== want.sync_word || long_flux !== want.long_flux ||
          track_done !== want.track_done || last_in_run !== want.last_in_run) begin
        if (nerr < 10) begin
          $display("word mismatch at %0t", $realtime);
          $display("  exp %h idx %0d s%b l%b d%b e%b", want.word, want.word_index,
                   want.sync_word, want.long_flux, want.track_done, want.last_in_run);
          $display("  got %h idx %0d s%b l%b d%b e%b", word, word_index,
                   sync_word, long_flux, track_done, last_in_run);
        end
        nerr++;
      end
    end
  endtask

  initial begin
    nerr    = 0;
    n_work  = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      cell_ticks = CELL_TICKS_RESET;
      mode       = MODE_NONE;
      tot_words  = TOTAL_WORDS_RESET;
      prev       = '0;
      win        = '1;
      nbits      = '0;
      ph         = PH_IDLE;
      lf_pend    = 1'b0;
      word_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CELL_TICKS:  cell_ticks = cfg_data[11:0];
          CFG_SYNC_MODE:   mode = cfg_data[1:0];
          CFG_TOTAL_WORDS: tot_words = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_word();
      if (in_valid && !in_stall) predict_beat(cmd, sample);
    end
    pending    <= word_q.size();
    errors     <= nerr;
    work_beats <= n_work;
  end

endmodule

// File: tb/flux_to_bitcell_sync_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flux_to_bitcell_sync_decoder_tb: stimulus and verdict for the data separator
// Directed extremes, then mostly well-formed tracks (start, preamble, FM or
// MFM sync pattern, jittered flux) with noise, random idling and a long
// receiver hold-off. Checking is done by fbsd_tb_checker.
// ----------------------------------------------------------------------------
module flux_to_bitcell_sync_decoder_tb;
  import fbsd_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int QUIET    = 3200;
  localparam int HOLD_LEN = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd = 1'b0;
  logic [15:0] sample = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] word;
  logic [15:0] word_index;
  logic        sync_word;
  logic        long_flux;
  logic        track_done;
  logic        last_in_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int          n_err;
  int          n_pending;
  int          n_work;

  logic        calm = 1'b0;
  logic        hold_req = 1'b0;
  int          hold_cyc = 0;
  int          cur_cell = 144;
  logic [15:0] ts = '0;

  flux_to_bitcell_sync_decoder DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .word(word), .word_index(word_index), .sync_word(sync_word),
    .long_flux(long_flux), .track_done(track_done), .last_in_run(last_in_run),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fbsd_tb_checker u_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .word(word), .word_index(word_index), .sync_word(sync_word),
    .long_flux(long_flux), .track_done(track_done), .last_in_run(last_in_run),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(n_err), .pending(n_pending), .work_beats(n_work)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stalls, or a long hold-off while hold_req is up
  always @(posedge clk) begin
    if (hold_req && hold_cyc < HOLD_LEN) begin
      out_stall <= 1'b1;
      hold_cyc  <= hold_cyc + 1;
    end else begin
      if (!hold_req) hold_cyc <= 0;
      out_stall <= !calm && ($urandom_range(0, 99) < 36);
    end
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic put_beat(input logic c, input logic [15:0] s);
    int gap;
    gap = 0;
    if (!calm) while ($urandom_range(0, 99) < 36) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    sample   <= s;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (QUIET) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_regs(input logic [11:0] ct, input logic [1:0] sm,
                            input logic [15:0] tw, input logic [3:0] junk);
    settle();
    put_reg(CFG_CELL_TICKS, {junk, ct});
    put_reg(CFG_SYNC_MODE, {14'd0, sm});
    put_reg(CFG_TOTAL_WORDS, tw);
    cfg_valid <= 1'b0;
    cur_cell = (ct < MIN_CELL) ? int'(MIN_CELL) : int'(ct);
  endtask

  // flux n cells after the previous one, jittered well inside the window
  task automatic flux(input int n);
    int j;
    j  = int'($urandom_range(0, cur_cell / 2)) - cur_cell / 4;
    ts = ts + 16'(n * cur_cell + j);
    put_beat(1'b1, ts);
  endtask

  task automatic feed_pattern(input logic [31:0] pat);
    int z;
    z = 0;
    for (int i = 31; i >= 0; i--) begin
      if (pat[i]) begin
        flux(z + 1);
        z = 0;
      end else begin
        z++;
      end
    end
  endtask

  task automatic capture_run(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        ts = 16'($urandom);
        put_beat(1'b1, ts);
      end else if (r < 10) flux(1);
      else if (r < 45) flux(2);
      else if (r < 75) flux(3);
      else if (r < 92) flux(4);
      else flux($urandom_range(5, 9));
    end
  endtask

  initial begin
    int          seq;
    int          r;
    int          n;
    logic [11:0] ct;
    logic [1:0]  sm;
    logic [15:0] tw;
    logic [31:0] pat;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: flux while idle, widest delta, flux after done
    put_beat(1'b1, 16'hFFFF);
    put_beat(1'b0, 16'hFFFF);
    put_beat(1'b1, 16'hFFFE);
    put_beat(1'b1, 16'h1234);

    // cell below minimum, spare sync mode, zero word count
    write_regs(12'd0, MODE_SPARE, 16'd0, 4'h0);
    put_beat(1'b0, 16'h0000);
    put_beat(1'b1, 16'hFFFF);

    // smallest cell, most words: one beat yields a full burst, then zero delta
    write_regs(12'd64, MODE_NONE, 16'hFFFF, 4'h0);
    put_beat(1'b0, 16'h8000);
    put_beat(1'b1, 16'h7FFF);
    put_beat(1'b1, 16'h7FFF);

    // largest cell with upper data bits set, long flux
    write_regs(12'd4095, MODE_NONE, 16'd2, 4'hF);
    ts = 16'($urandom);
    put_beat(1'b0, ts);
    flux(8);
    flux(1);

    // sync mode dropped while hunting never matches
    write_regs(12'd150, MODE_MFM, 16'd3, 4'h5);
    ts = 16'($urandom);
    put_beat(1'b0, ts);
    flux(2);
    flux(3);
    write_regs(12'd150, MODE_NONE, 16'd3, 4'hA);
    flux(2);
    flux(4);
    write_regs(12'd150, MODE_SPARE, 16'd3, 4'h0);
    flux(2);

    seq = 0;
    while (n_work < 230) begin
      if (seq == 3) calm <= 1'b1;
      if (seq == 4) calm <= 1'b0;
      r  = $urandom_range(0, 99);
      ct = (r < 10) ? 12'($urandom_range(0, 63)) :
           (r < 18) ? 12'($urandom_range(3000, 4095)) : 12'($urandom_range(64, 400));
      r  = $urandom_range(0, 99);
      sm = (r < 25) ? MODE_NONE : (r < 60) ? MODE_FM : (r < 95) ? MODE_MFM : MODE_SPARE;
      r  = $urandom_range(0, 99);
      tw = (r < 80) ? 16'($urandom_range(1, 3)) :
           (r < 95) ? 16'($urandom_range(4, 8)) : 16'($urandom);
      if (seq == 2) begin
        ct = 12'd100;
        sm = MODE_NONE;
        tw = 16'd8;
      end
      write_regs(ct, sm, tw, 4'($urandom));
      if (seq == 2) hold_req <= 1'b1;
      ts = 16'($urandom);
      put_beat(1'b0, ts);
      if (sm == MODE_FM || sm == MODE_MFM) begin
        repeat ($urandom_range(1, 3)) flux($urandom_range(1, 4));
        pat = (sm == MODE_FM) ? (FM_SYNC | ($urandom & ~FM_MASK)) : MFM_SYNC;
        if ($urandom_range(0, 7) == 0) pat = pat ^ (32'd1 << $urandom_range(1, 31));
        feed_pattern(pat);
      end
      n = ((tw > 16'd4) ? 4 : int'(tw)) * 12 + $urandom_range(0, 5);
      capture_run((seq == 2) ? 60 : n);
      if (seq == 2) hold_req <= 1'b0;
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(2, 5)) put_beat($urandom_range(0, 3) != 0, 16'($urandom));
      seq++;
    end

    settle();
    if (n_err == 0 && n_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
